>>> src/cfsc_pkg.sv
// ----------------------------------------------------------------------------
// cfsc_pkg
// Shared types, constants and helpers of the CSV field splitter and cleaner.
// ----------------------------------------------------------------------------
package cfsc_pkg;

  localparam int unsigned FieldLenBits  = 12;
  localparam int unsigned FieldIndexMax = 16;
  localparam int unsigned FieldIdxW     = $clog2(FieldIndexMax + 1);
  localparam int unsigned FieldNumW     = 4;
  localparam int unsigned MaxResults    = 3;
  localparam int unsigned ResCntW       = 2;
  localparam int unsigned QueueDepth    = 4;
  localparam int unsigned QPtrW         = $clog2(QueueDepth);
  localparam int unsigned CfgIdxW       = 1;
  localparam int unsigned CfgDataW      = 12;

  localparam logic [FieldLenBits-1:0] RawLimMax   = FieldLenBits'((1 << FieldLenBits) - 2);
  localparam logic [FieldLenBits-1:0] RawLimReset = FieldLenBits'(1998);
  localparam logic [FieldIdxW-1:0]    FmaxReset   = FieldIdxW'(14);
  localparam logic [FieldIdxW-1:0]    FmaxMax     = FieldIdxW'(FieldIndexMax);

  localparam logic [CfgIdxW-1:0] RegMaxFields  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegRawLenLim  = 1'd1;

  localparam logic KindByte   = 1'b0;
  localparam logic KindMarker = 1'b1;

  localparam logic [7:0] ChLBracket = 8'h5B;
  localparam logic [7:0] ChRBracket = 8'h5D;
  localparam logic [7:0] ChApos     = 8'h27;
  localparam logic [7:0] ChQuote    = 8'h22;
  localparam logic [7:0] ChLf       = 8'h0A;
  localparam logic [7:0] ChCr       = 8'h0D;
  localparam logic [7:0] ChComma    = 8'h2C;
  localparam logic [7:0] ChSpace    = 8'h20;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic                 out_kind;
    logic [7:0]           out_byte;
    logic [FieldNumW-1:0] field_number;
    logic [FieldIdxW-1:0] field_total;
    logic                 line_done;
    logic                 last;
  } out_item_t;

  typedef struct packed {
    logic [ResCntW-1:0]           cnt;
    out_item_t [MaxResults-1:0]   res;
  } plan_t;

  function automatic out_item_t mk_res(logic kind, logic [7:0] b,
                                       logic [FieldIdxW-1:0] num,
                                       logic [FieldIdxW-1:0] total, logic done);
    out_item_t r;
    r.out_kind     = kind;
    r.out_byte     = b;
    r.field_number = num[FieldNumW-1:0];
    r.field_total  = done ? total : '0;
    r.line_done    = done;
    r.last         = 1'b0;
    return r;
  endfunction

endpackage

>>> src/csv_field_splitter_cleaner.sv
// ----------------------------------------------------------------------------
// csv_field_splitter_cleaner
// Each byte's results are queued before they show. Throughput: one byte per
// cycle in unless full; one result per cycle out while not empty, up to three
// results per byte, so output pops set the sustained rate when many bytes
// expand; a four-entry queue between front and back absorbs the bursts.
// Reset: asynchronous active low; clears line state and the queue and
// loads max_fields 14 and raw_len_limit 1998.
// ----------------------------------------------------------------------------
module csv_field_splitter_cleaner (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  cfsc_pkg::in_item_t            in_item_i,
  output logic                          empty,
  input  logic                          pop,
  output cfsc_pkg::out_item_t           out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cfsc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cfsc_pkg::CfgDataW-1:0] cfg_data_i
);

  logic            q_wr;
  cfsc_pkg::plan_t q_wr_data;
  logic            q_rd;
  logic            q_valid;
  cfsc_pkg::plan_t q_head;

  assign cfg_ready_o = 1'b1;

  cfsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .in_item_i   (in_item_i),
    .q_full_i    (full),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_wr_o      (q_wr),
    .q_wr_data_o (q_wr_data)
  );

  cfsc_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_wr_data),
    .rd_i      (q_rd),
    .full_o    (full),
    .valid_o   (q_valid),
    .rd_data_o (q_head)
  );

  cfsc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (q_head),
    .pop          (pop),
    .empty        (empty),
    .out_item_o   (out_item_o),
    .q_rd_o       (q_rd)
  );

endmodule

>>> src/cfsc_front.sv
// ----------------------------------------------------------------------------
// cfsc_front
// Accepts raw bytes, tracks line and field state, and builds the list of
// results each byte causes.
// ----------------------------------------------------------------------------
module cfsc_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  input  cfsc_pkg::in_item_t                in_item_i,
  input  logic                              q_full_i,
  input  logic                              cfg_valid_i,
  input  logic [cfsc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [cfsc_pkg::CfgDataW-1:0]     cfg_data_i,
  output logic                              q_wr_o,
  output cfsc_pkg::plan_t                   q_wr_data_o
);

  logic [cfsc_pkg::FieldIdxW-1:0]    fmax_q, fmax_d;
  logic [cfsc_pkg::FieldLenBits-1:0] raw_lim_q, raw_lim_d;

  logic                              inq_q, inq_d;
  logic [cfsc_pkg::FieldLenBits-1:0] raw_q, raw_d;
  logic [cfsc_pkg::FieldLenBits-1:0] cc_q, cc_d;
  logic                              sp_q, sp_d;
  logic [cfsc_pkg::FieldIdxW-1:0]    fi_q, fi_d;
  logic                              drop_q, drop_d;

  logic                              accept;
  cfsc_pkg::plan_t                   plan;

  assign accept = push && !q_full_i;

  // config registers, stored already saturated
  always_comb begin
    fmax_d    = fmax_q;
    raw_lim_d = raw_lim_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cfsc_pkg::RegMaxFields: begin
          if (cfg_data_i[cfsc_pkg::FieldIdxW-1:0] == '0) begin
            fmax_d = cfsc_pkg::FieldIdxW'(1);
          end else if (cfg_data_i[cfsc_pkg::FieldIdxW-1:0] > cfsc_pkg::FmaxMax) begin
            fmax_d = cfsc_pkg::FmaxMax;
          end else begin
            fmax_d = cfg_data_i[cfsc_pkg::FieldIdxW-1:0];
          end
        end
        cfsc_pkg::RegRawLenLim: begin
          if (cfg_data_i[cfsc_pkg::FieldLenBits-1:0] > cfsc_pkg::RawLimMax) begin
            raw_lim_d = cfsc_pkg::RawLimMax;
          end else begin
            raw_lim_d = cfg_data_i[cfsc_pkg::FieldLenBits-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    logic [7:0]                        c;
    logic                              eol;
    logic [cfsc_pkg::FieldIdxW-1:0]    closed;
    logic                              sep_full;
    logic                              keep;
    logic [cfsc_pkg::FieldLenBits-1:0] cc1;
    logic [cfsc_pkg::FieldLenBits-1:0] cc2;
    logic [cfsc_pkg::ResCntW-1:0]      n;

    c        = in_item_i.in_byte;
    eol      = in_item_i.line_end;
    closed   = fi_q + cfsc_pkg::FieldIdxW'(1);
    sep_full = 1'b0;
    keep     = !(c == cfsc_pkg::ChLBracket || c == cfsc_pkg::ChRBracket ||
                 c == cfsc_pkg::ChApos || c == cfsc_pkg::ChLf || c == cfsc_pkg::ChCr);
    cc1      = cc_q;
    cc2      = cc_q;
    n        = '0;
    plan     = '0;

    inq_d  = inq_q;
    raw_d  = raw_q;
    cc_d   = cc_q;
    sp_d   = sp_q;
    fi_d   = fi_q;
    drop_d = drop_q;

    if (drop_q) begin
      if (eol) begin
        inq_d  = 1'b0;
        raw_d  = '0;
        cc_d   = '0;
        sp_d   = 1'b0;
        fi_d   = '0;
        drop_d = 1'b0;
      end
    end else begin
      if (c == cfsc_pkg::ChQuote) begin
        inq_d = ~inq_q;
      end else if (c == cfsc_pkg::ChComma && !inq_q) begin
        plan.res[n] = cfsc_pkg::mk_res(cfsc_pkg::KindMarker, 8'h00, fi_q, closed,
                                       closed >= fmax_q);
        n     = n + cfsc_pkg::ResCntW'(1);
        raw_d = '0;
        cc_d  = '0;
        sp_d  = 1'b0;
        fi_d  = closed;
        if (closed >= fmax_q) begin
          sep_full = 1'b1;
          if (eol) begin
            inq_d = 1'b0;
            fi_d  = '0;
          end else begin
            drop_d = 1'b1;
          end
        end
      end else if (raw_q < raw_lim_q) begin
        raw_d = raw_q + cfsc_pkg::FieldLenBits'(1);
        if (sp_q) begin
          sp_d = 1'b0;
          if (c != cfsc_pkg::ChSpace && cc_q <= raw_lim_q) begin
            plan.res[n] = cfsc_pkg::mk_res(cfsc_pkg::KindByte, cfsc_pkg::ChSpace, fi_q,
                                           '0, 1'b0);
            n   = n + cfsc_pkg::ResCntW'(1);
            cc1 = cc_q + cfsc_pkg::FieldLenBits'(1);
          end
        end
        cc2 = cc1;
        if (keep && cc1 <= raw_lim_q) begin
          plan.res[n] = cfsc_pkg::mk_res(cfsc_pkg::KindByte, c, fi_q, '0, 1'b0);
          n   = n + cfsc_pkg::ResCntW'(1);
          cc2 = cc1 + cfsc_pkg::FieldLenBits'(1);
          if (c == cfsc_pkg::ChComma && cc2 <= raw_lim_q) begin
            sp_d = 1'b1;
          end
        end
        cc_d = cc2;
      end

      if (eol && !sep_full) begin
        plan.res[n] = cfsc_pkg::mk_res(cfsc_pkg::KindMarker, 8'h00, fi_d,
                                       fi_d + cfsc_pkg::FieldIdxW'(1), 1'b1);
        n      = n + cfsc_pkg::ResCntW'(1);
        inq_d  = 1'b0;
        raw_d  = '0;
        cc_d   = '0;
        sp_d   = 1'b0;
        fi_d   = '0;
        drop_d = 1'b0;
      end
    end

    if (n != '0) begin
      plan.res[n - cfsc_pkg::ResCntW'(1)].last = 1'b1;
    end
    plan.cnt = n;
  end

  assign q_wr_o      = accept && (plan.cnt != '0);
  assign q_wr_data_o = plan;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmax_q    <= cfsc_pkg::FmaxReset;
      raw_lim_q <= cfsc_pkg::RawLimReset;
      inq_q     <= 1'b0;
      raw_q     <= '0;
      cc_q      <= '0;
      sp_q      <= 1'b0;
      fi_q      <= '0;
      drop_q    <= 1'b0;
    end else begin
      fmax_q    <= fmax_d;
      raw_lim_q <= raw_lim_d;
      if (accept) begin
        inq_q  <= inq_d;
        raw_q  <= raw_d;
        cc_q   <= cc_d;
        sp_q   <= sp_d;
        fi_q   <= fi_d;
        drop_q <= drop_d;
      end
    end
  end

endmodule

>>> src/cfsc_queue.sv
// ----------------------------------------------------------------------------
// cfsc_queue
// Short queue of per-byte result lists between the front and back parts.
// ----------------------------------------------------------------------------
module cfsc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  cfsc_pkg::plan_t wr_data_i,
  input  logic            rd_i,
  output logic            full_o,
  output logic            valid_o,
  output cfsc_pkg::plan_t rd_data_o
);

  cfsc_pkg::plan_t                mem_q [cfsc_pkg::QueueDepth];
  logic [cfsc_pkg::QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [cfsc_pkg::QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [cfsc_pkg::QPtrW:0]       count_q, count_d;

  assign full_o    = (count_q == (cfsc_pkg::QPtrW + 1)'(cfsc_pkg::QueueDepth));
  assign valid_o   = (count_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_i) begin
      wr_ptr_d = wr_ptr_q + cfsc_pkg::QPtrW'(1);
    end
    if (rd_i) begin
      rd_ptr_d = rd_ptr_q + cfsc_pkg::QPtrW'(1);
    end
    if (wr_i && !rd_i) begin
      count_d = count_q + (cfsc_pkg::QPtrW + 1)'(1);
    end else if (rd_i && !wr_i) begin
      count_d = count_q - (cfsc_pkg::QPtrW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !full_o)
    else $error("queue written while full");

  a_no_read_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> valid_o)
    else $error("queue read while empty");

  a_no_empty_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> (wr_data_i.cnt != '0))
    else $error("empty result list queued");

  a_count_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!wr_i && !rd_i) |=> $stable(count_q))
    else $error("queue count moved without access");

endmodule

>>> src/cfsc_back.sv
// ----------------------------------------------------------------------------
// cfsc_back
// Walks the head result list of the queue and presents one result at a time.
// ----------------------------------------------------------------------------
module cfsc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  cfsc_pkg::plan_t      head_i,
  input  logic                 pop,
  output logic                 empty,
  output cfsc_pkg::out_item_t  out_item_o,
  output logic                 q_rd_o
);

  logic [cfsc_pkg::ResCntW-1:0] sub_q, sub_d;
  logic                         take;
  logic                         at_end;

  assign empty      = !head_valid_i;
  assign out_item_o = head_i.res[sub_q];
  assign take       = pop && head_valid_i;
  assign at_end     = (sub_q == head_i.cnt - cfsc_pkg::ResCntW'(1));
  assign q_rd_o     = take && at_end;

  always_comb begin
    sub_d = sub_q;
    if (take) begin
      sub_d = at_end ? '0 : sub_q + cfsc_pkg::ResCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= '0;
    end else begin
      sub_q <= sub_d;
    end
  end

endmodule
